>>> hw/rtl/length_prefixed_frame_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed frame parser checker
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_PARSER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_ASSERT_SVH

// same-cycle implication
`define LPFP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LPFP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/lpfp_pkg.sv
// ----------------------------------------------------------------------------
// lpfp_pkg
// Shared types and constants for the length-prefixed frame parser.
// ----------------------------------------------------------------------------
package lpfp_pkg;

   localparam int LENGTH_BYTES = 4;            // bytes in the length prefix
   localparam int ACC_BYTES    = 4;            // bytes the accumulator holds
   localparam int ACC_W        = 8 * ACC_BYTES;
   localparam int HDR_CNT_W    = $clog2(LENGTH_BYTES + 1);
   localparam int SHIFT_W      = $clog2(ACC_W) + 1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_LENGTH   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_LENGTH   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CMD_KIND     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SEC_KIND     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SEC_KIND_EN  = 3'd4;

   localparam logic [31:0] MIN_LENGTH_RST = 32'd1;
   localparam logic [31:0] MAX_LENGTH_RST = 32'd65536;
   localparam logic [7:0]  CMD_KIND_RST   = 8'd1;
   localparam logic [7:0]  SEC_KIND_RST   = 8'd2;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_LENGTH = 2'd1;
   localparam logic [1:0] ERR_KIND   = 2'd2;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_KIND,
      PH_PAYLOAD,
      PH_ERROR
   } phase_type;

   typedef struct packed {
      logic [31:0] min_length;
      logic [31:0] max_length;
      logic [7:0]  command_kind_code;
      logic [7:0]  second_kind_code;
      logic        second_kind_enable;
   } cfg_type;

   typedef struct packed {
      logic [1:0] error_code;
      logic       end_of_frame;
      logic       frame_kind;
      logic       is_kind_byte;
      logic [7:0] byte_value;
   } rsp_type;

endpackage

>>> hw/rtl/lpfp_csr.sv
// ----------------------------------------------------------------------------
// lpfp_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module lpfp_csr
   import lpfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_MIN_LENGTH:  cfg_in.min_length         = csr_wdata[31:0];
            CSR_MAX_LENGTH:  cfg_in.max_length         = csr_wdata[31:0];
            CSR_CMD_KIND:    cfg_in.command_kind_code  = csr_wdata[7:0];
            CSR_SEC_KIND:    cfg_in.second_kind_code   = csr_wdata[7:0];
            CSR_SEC_KIND_EN: cfg_in.second_kind_enable = csr_wdata[0];
            default: ;  // unmapped index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_length         <= MIN_LENGTH_RST;
         cfg_ff.max_length         <= MAX_LENGTH_RST;
         cfg_ff.command_kind_code  <= CMD_KIND_RST;
         cfg_ff.second_kind_code   <= SEC_KIND_RST;
         cfg_ff.second_kind_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/lpfp_core.sv
// ----------------------------------------------------------------------------
// lpfp_core
// Frame parse state machine: length prefix, kind check, payload count.
// ----------------------------------------------------------------------------
module lpfp_core
   import lpfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       byte_accept,
   input  logic [7:0] rx_byte,
   output logic       res_valid,
   output rsp_type    res
);

   phase_type              phase_ff, phase_in;
   logic [HDR_CNT_W-1:0]   hdr_cnt_ff, hdr_cnt_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [31:0]            rem_ff, rem_in;
   logic                   kind_ff, kind_in;

   logic [ACC_W-1:0]       acc_upd;
   logic                   hdr_last;
   logic                   len_bad;
   logic                   match_cmd;
   logic                   match_sec;
   logic                   last_byte;

   // length prefix assembly; bytes past the accumulator saturate if nonzero
   always_comb begin
      acc_upd = acc_ff;
      if (32'(hdr_cnt_ff) < ACC_BYTES) begin
         acc_upd = acc_ff | (ACC_W'(rx_byte) << (SHIFT_W'(hdr_cnt_ff) << 3));
      end else if (rx_byte != 8'd0) begin
         acc_upd = '1;
      end
   end

   assign hdr_last  = (hdr_cnt_ff == HDR_CNT_W'(LENGTH_BYTES - 1));
   assign len_bad   = (acc_upd == '0) || (acc_upd < cfg.min_length) ||
                      (acc_upd > cfg.max_length);
   assign match_cmd = (rx_byte == cfg.command_kind_code);
   assign match_sec = cfg.second_kind_enable && (rx_byte == cfg.second_kind_code);
   assign last_byte = (rem_ff <= 32'd1);

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (byte_accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (hdr_last) begin
                  phase_in = len_bad ? PH_ERROR : PH_KIND;
               end
            end
            PH_KIND: begin
               if (!match_cmd && !match_sec) begin
                  phase_in = PH_ERROR;
               end else begin
                  phase_in = last_byte ? PH_HEADER : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: phase_in = last_byte ? PH_HEADER : PH_PAYLOAD;
            PH_ERROR:   phase_in = PH_ERROR;
            default:    phase_in = PH_ERROR;
         endcase
      end
   end

   // outputs and datapath
   always_comb begin
      res_valid       = 1'b0;
      res             = '0;
      hdr_cnt_in      = hdr_cnt_ff;
      acc_in          = acc_ff;
      rem_in          = rem_ff;
      kind_in         = kind_ff;
      if (byte_accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (hdr_last) begin
                  hdr_cnt_in = '0;
                  acc_in     = '0;
                  if (len_bad) begin
                     res_valid      = 1'b1;
                     res.error_code = ERR_LENGTH;
                  end else begin
                     rem_in = acc_upd[31:0];
                  end
               end else begin
                  hdr_cnt_in = hdr_cnt_ff + 1'b1;
                  acc_in     = acc_upd;
               end
            end
            PH_KIND: begin
               res_valid = 1'b1;
               if (!match_cmd && !match_sec) begin
                  res.error_code = ERR_KIND;
               end else begin
                  kind_in          = !match_cmd;
                  res.byte_value   = rx_byte;
                  res.is_kind_byte = 1'b1;
                  res.frame_kind   = !match_cmd;
                  res.end_of_frame = last_byte;
                  res.error_code   = ERR_NONE;
                  rem_in           = (rem_ff != 32'd0) ? rem_ff - 32'd1 : rem_ff;
               end
            end
            PH_PAYLOAD: begin
               res_valid        = 1'b1;
               res.byte_value   = rx_byte;
               res.frame_kind   = kind_ff;
               res.end_of_frame = last_byte;
               res.error_code   = ERR_NONE;
               rem_in           = (rem_ff != 32'd0) ? rem_ff - 32'd1 : rem_ff;
            end
            PH_ERROR: ;  // dropped until reset
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_cnt_ff <= '0;
         acc_ff     <= '0;
         rem_ff     <= '0;
         kind_ff    <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         acc_ff     <= acc_in;
         rem_ff     <= rem_in;
         kind_ff    <= kind_in;
      end
   end

endmodule

>>> hw/rtl/lpfp_skid.sv
// ----------------------------------------------------------------------------
// lpfp_skid
// Two-entry result register: output stage plus skid entry.
// ----------------------------------------------------------------------------
module lpfp_skid
   import lpfp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_data_ff, main_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    pop;
   logic    push;

   assign in_ready = !skid_valid_ff;
   assign pop      = main_valid_ff && out_ready;
   assign push     = in_valid && !skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_data_in  = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule

>>> hw/rtl/length_prefixed_frame_parser.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser
// Splits a byte stream into length-prefixed frames and checks each header.
// ----------------------------------------------------------------------------
// Input beats on req_* carry one received byte each. Every frame opens with a
// 4-byte little-endian length (kind byte plus payload), then the kind byte.
// Length bytes give no output beat; the kind byte and each payload byte give
// one beat on rsp_*, with rsp_tlast on the frame's last byte.
// A bad length or unknown kind gives one error beat, then every later byte is
// taken and dropped until reset.
// Throughput: one byte per cycle while req_tready stays high. A byte's
// result beat is registered in the output stage, or in the skid entry when
// the output stage is held; the parse step is a counter update and the
// 32-bit length range compares between state and result register.
// A two-entry output register lets req_tready stay high while one result
// waits; req_tready drops only once two results are held by a stalled
// receiver, and rises again the cycle after rsp_tready takes one.
// Reset (synchronous) restores the register defaults, empties the output
// register and starts in the length phase with req_tready high. Configuration
// is to be written through csr_* while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser
   import lpfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] rx_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // [7:0] byte_value, [9:8] error_code
   output logic [1:0]            rsp_tuser,   // [0] is_kind_byte, [1] frame_kind
   output logic                  rsp_tlast,   // end_of_frame
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;
   logic    byte_accept;
   logic    res_valid;
   rsp_type res;
   rsp_type out_data;

   assign byte_accept = req_tvalid && req_tready;

   lpfp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lpfp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .byte_accept (byte_accept),
      .rx_byte     (req_tdata),
      .res_valid   (res_valid),
      .res         (res)
   );

   lpfp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (req_tready),
      .in_data   (res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {6'd0, out_data.error_code, out_data.byte_value};
   assign rsp_tuser = {out_data.frame_kind, out_data.is_kind_byte};
   assign rsp_tlast = out_data.end_of_frame;

endmodule

>>> hw/rtl/lpfp_checker.sv
// ----------------------------------------------------------------------------
// lpfp_checker
// Port-level checks for the length-prefixed frame parser.
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_parser_assert.svh"

module lpfp_checker
   import lpfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tready,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [15:0]           rsp_tdata,
   input  logic [1:0]            rsp_tuser,
   input  logic                  rsp_tlast
);

   // stalled beat holds
   `LPFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast),
      "rsp beat changed while stalled")

   // error beats carry no byte and no flags
   `LPFP_ASSERT_SAME(a_err_clean, clock, reset, rsp_tvalid && rsp_tdata[9:8] != ERR_NONE,
      rsp_tdata[7:0] == 8'd0 && rsp_tuser == 2'd0 && !rsp_tlast,
      "error beat with data or flags set")

   // only defined error codes, padding stays zero
   `LPFP_ASSERT_SAME(a_err_code, clock, reset, rsp_tvalid,
      rsp_tdata[9:8] != 2'd3 && rsp_tdata[15:10] == 6'd0,
      "bad error code or padding in rsp beat")

   // output register empty right after reset
   `LPFP_ASSERT_SAME(a_rst_ready, clock, reset, $past(reset),
      req_tready && !rsp_tvalid,
      "block not empty after reset")

endmodule

bind length_prefixed_frame_parser lpfp_checker u_lpfp_checker (.*);

>>> verif/length_prefixed_frame_parser_checker.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser_checker
// Watches the byte, result and register ports of the frame parser, predicts
// the result beat for each byte taken, and compares it with what comes out.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser_checker
   import lpfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] rx_byte
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [15:0]           rsp_tdata,   // [7:0] byte_value, [9:8] error_code
   input  logic [1:0]            rsp_tuser,   // [0] is_kind_byte, [1] frame_kind
   input  logic                  rsp_tlast,   // end_of_frame
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_count,
   output int                    beat_count
);
   timeunit 1ns;
   timeprecision 1ps;

   cfg_type              regs;
   phase_type            phase;
   logic [HDR_CNT_W-1:0] hdr_count;
   logic [ACC_W-1:0]     len_acc;
   logic [31:0]          remaining;
   logic                 cur_kind;
   logic                 err_latched;
   rsp_type              expected_beats[$];
   int                   errors;
   int                   checked;

   // Advances the frame state by one byte; returns 1 when the byte yields a beat.
   function automatic logic parse_byte(input logic [7:0] rx, output rsp_type beat);
      logic [31:0]     frame_len;
      logic [ACC_W-1:0] wide_rx;
      int unsigned     pos;
      beat = '0;
      if (err_latched || phase == PH_ERROR)
         return 1'b0;
      if (phase == PH_HEADER) begin
         pos = 32'(hdr_count);
         wide_rx = ACC_W'(rx);
         if (pos < ACC_BYTES)
            len_acc |= wide_rx << (8 * pos);
         else if (rx != 8'd0)
            len_acc = '1;   // prefix wider than the accumulator saturates
         hdr_count = hdr_count + 1'b1;
         if (hdr_count < LENGTH_BYTES)
            return 1'b0;
         frame_len = len_acc[31:0];
         hdr_count = '0;
         len_acc   = '0;
         // zero length has no room for the kind byte, whatever min_length says
         if (frame_len == 32'd0 || frame_len < regs.min_length ||
             frame_len > regs.max_length) begin
            err_latched     = 1'b1;
            phase           = PH_ERROR;
            beat.error_code = ERR_LENGTH;
            return 1'b1;
         end
         remaining = frame_len;
         phase     = PH_KIND;
         return 1'b0;
      end
      if (phase == PH_KIND) begin
         // command code wins when both codes match
         if (rx == regs.command_kind_code)
            cur_kind = 1'b0;
         else if (regs.second_kind_enable && rx == regs.second_kind_code)
            cur_kind = 1'b1;
         else begin
            err_latched     = 1'b1;
            phase           = PH_ERROR;
            beat.error_code = ERR_KIND;
            return 1'b1;
         end
         beat.is_kind_byte = 1'b1;
      end
      beat.byte_value   = rx;
      beat.frame_kind   = cur_kind;
      beat.end_of_frame = (remaining <= 32'd1);
      beat.error_code   = ERR_NONE;
      if (remaining != 32'd0)
         remaining = remaining - 32'd1;
      phase = (remaining == 32'd0) ? PH_HEADER : PH_PAYLOAD;
      return 1'b1;
   endfunction

   task automatic note_failure(input string what, input rsp_type want, input rsp_type got);
      errors++;
      if (errors <= 10)
         $display("[%0t] %s: expected byte=%02h kind_byte=%0b kind=%0b last=%0b err=%0d,",
                  $realtime, what, want.byte_value, want.is_kind_byte, want.frame_kind,
                  want.end_of_frame, want.error_code,
                  " got byte=%02h kind_byte=%0b kind=%0b last=%0b err=%0d",
                  got.byte_value, got.is_kind_byte, got.frame_kind, got.end_of_frame,
                  got.error_code);
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      rsp_type pred;
      if (reset) begin
         regs        = '{MIN_LENGTH_RST, MAX_LENGTH_RST, CMD_KIND_RST, SEC_KIND_RST, 1'b0};
         phase       = PH_HEADER;
         hdr_count   = '0;
         len_acc     = '0;
         remaining   = '0;
         cur_kind    = 1'b0;
         err_latched = 1'b0;
         expected_beats.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_MIN_LENGTH:  regs.min_length         = csr_wdata;
               CSR_MAX_LENGTH:  regs.max_length         = csr_wdata;
               CSR_CMD_KIND:    regs.command_kind_code  = csr_wdata[7:0];
               CSR_SEC_KIND:    regs.second_kind_code   = csr_wdata[7:0];
               CSR_SEC_KIND_EN: regs.second_kind_enable = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.byte_value   = rsp_tdata[7:0];
            got.error_code   = rsp_tdata[9:8];
            got.is_kind_byte = rsp_tuser[0];
            got.frame_kind   = rsp_tuser[1];
            got.end_of_frame = rsp_tlast;
            checked++;
            if (expected_beats.size() == 0) begin
               note_failure("beat with nothing expected", '0, got);
            end else begin
               want = expected_beats.pop_front();
               if (got.byte_value   !== want.byte_value   ||
                   got.error_code   !== want.error_code   ||
                   got.is_kind_byte !== want.is_kind_byte ||
                   got.frame_kind   !== want.frame_kind   ||
                   got.end_of_frame !== want.end_of_frame)
                  note_failure("beat mismatch", want, got);
            end
         end
         if (req_tvalid && req_tready) begin
            if (parse_byte(req_tdata, pred))
               expected_beats.push_back(pred);
         end
      end
      fail_count    <= errors;
      pending_count <= expected_beats.size();
      beat_count    <= checked;
   end

endmodule

>>> verif/length_prefixed_frame_parser_tb.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser_tb
// Feeds framed byte streams through the parser under several register
// settings and random flow control, ending with one latched header error.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lpfp_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 3'd7;
   localparam int HOLD_CYCLES = 64;

   typedef enum int {
      BAD_ZERO_LEN,
      BAD_SHORT_LEN,
      BAD_LONG_LEN,
      BAD_KIND,
      BAD_KIND_DISABLED
   } bad_frame_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int fail_count;
   int pending_count;
   int beat_count;

   int send_idle_pct = 16;
   int recv_idle_pct = 80;
   int hold_token    = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int bytes_sent    = 0;
   int frames_sent   = 0;

   length_prefixed_frame_parser DUT (.*);

   length_prefixed_frame_parser_checker frame_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("FAILED: results differ");
      $finish;
   end

   // receiver: random back-pressure, plus one long hold when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         hold_seen  <= 0;
      end else if (hold_seen != hold_token) begin
         hold_seen  <= hold_token;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      bytes_sent++;
   endtask

   // little-endian length prefix
   task automatic send_header(input logic [31:0] len);
      for (int i = 0; i < LENGTH_BYTES; i++)
         send_byte(8'(len >> (8 * i)));
      frames_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do
         @(posedge clock);
      while (pending_count != 0);
      // a trailing length byte gives no beat; let it settle
      repeat (4) @(posedge clock);
   endtask

   // upper bits of the narrow registers carry junk that must be ignored
   task automatic load_config(input cfg_type cfg);
      logic [CSR_ADDR_W-1:0] addr_list [6];
      logic [CSR_DATA_W-1:0] data_list [6];
      addr_list = '{CSR_MIN_LENGTH, CSR_MAX_LENGTH, CSR_CMD_KIND, CSR_SEC_KIND,
                    CSR_SEC_KIND_EN, CSR_UNUSED};
      data_list = '{cfg.min_length,
                    cfg.max_length,
                    ($urandom() & 32'hFFFF_FF00) | 32'(cfg.command_kind_code),
                    ($urandom() & 32'hFFFF_FF00) | 32'(cfg.second_kind_code),
                    ($urandom() & 32'hFFFF_FFFE) | 32'(cfg.second_kind_enable),
                    $urandom()};
      csr_we <= 1'b1;
      foreach (addr_list[i]) begin
         csr_addr  <= addr_list[i];
         csr_wdata <= data_list[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      repeat (2) @(posedge clock);
   endtask

   // well-formed frames with random payload; lengths mostly short, with the
   // window edges and an occasional long frame mixed in
   task automatic run_phase(input cfg_type cfg, input int budget);
      int              start;
      int unsigned     roll;
      longint unsigned top;
      logic [31:0]     len;
      logic [7:0]      kind;
      start = bytes_sent;
      while (bytes_sent - start < budget) begin
         roll = $urandom_range(99);
         top  = longint'(cfg.min_length) + ((roll < 5) ? 300 : 24);
         if (top > cfg.max_length)
            top = cfg.max_length;
         if (roll >= 5 && roll < 15)
            len = cfg.min_length;
         else if (roll >= 15 && roll < 25)
            len = 32'(top);
         else
            len = $urandom_range(32'(top), cfg.min_length);
         kind = (cfg.second_kind_enable && $urandom_range(1)) ? cfg.second_kind_code
                                                               : cfg.command_kind_code;
         send_header(len);
         send_byte(kind);
         repeat (len - 1)
            send_byte(8'($urandom_range(255)));
         if ($urandom_range(39) == 0)
            wait_idle();
      end
   endtask

   initial begin
      cfg_type       cfg;
      bad_frame_type bad;
      logic [7:0]    odd_kind;
      int            waited;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: command frames only
      cfg = '{MIN_LENGTH_RST, MAX_LENGTH_RST, CMD_KIND_RST, SEC_KIND_RST, 1'b0};
      send_header(32'd1);
      send_byte(CMD_KIND_RST);
      send_header(32'd3);
      send_byte(CMD_KIND_RST);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_header(32'd2);
      send_byte(CMD_KIND_RST);
      send_byte(8'h80);
      run_phase(cfg, 300);
      wait_idle();

      // kind byte alone makes the frame; codes at both ends of their range
      cfg = '{32'd1, 32'd1, 8'h00, 8'hFF, 1'b1};
      load_config(cfg);
      send_header(32'd1);
      send_byte(8'h00);
      send_header(32'd1);
      send_byte(8'hFF);
      run_phase(cfg, 250);
      wait_idle();

      send_idle_pct = 80;
      recv_idle_pct <= 16;
      cfg = '{32'd3, 32'd40, 8'hFF, 8'h00, 1'b1};
      load_config(cfg);
      run_phase(cfg, 300);
      wait_idle();

      // equal codes: every frame is a command frame
      cfg = '{32'd1, 32'hFFFF_FFFF, 8'h07, 8'h07, 1'b1};
      load_config(cfg);
      run_phase(cfg, 300);
      wait_idle();

      send_idle_pct = 0;
      recv_idle_pct <= 0;
      cfg.min_length         = $urandom_range(8, 1);
      cfg.max_length         = cfg.min_length + $urandom_range(60);
      cfg.command_kind_code  = 8'($urandom_range(255));
      cfg.second_kind_code   = 8'($urandom_range(255));
      cfg.second_kind_enable = 1'($urandom_range(1));
      load_config(cfg);
      hold_token <= hold_token + 1;   // receiver stalls while bytes keep coming
      run_phase(cfg, 350);
      wait_idle();

      // one header error per run; it latches until reset
      bad = bad_frame_type'($urandom_range(4));
      case (bad)
         BAD_ZERO_LEN, BAD_SHORT_LEN: begin
            cfg.min_length = '1;
            cfg.max_length = '1;
            load_config(cfg);
            send_header((bad == BAD_ZERO_LEN) ? 32'd0 : 32'($urandom_range(200, 1)));
         end
         BAD_LONG_LEN: begin
            send_header(32'hFFFF_FFFF);
         end
         BAD_KIND: begin
            send_header(cfg.min_length);
            do
               odd_kind = 8'($urandom_range(255));
            while (odd_kind == cfg.command_kind_code ||
                   (cfg.second_kind_enable && odd_kind == cfg.second_kind_code));
            send_byte(odd_kind);
         end
         BAD_KIND_DISABLED: begin
            cfg.second_kind_enable = 1'b0;
            if (cfg.second_kind_code == cfg.command_kind_code)
               cfg.second_kind_code = ~cfg.command_kind_code;
            load_config(cfg);
            send_header(cfg.min_length);
            send_byte(cfg.second_kind_code);
         end
         default: ;
      endcase
      // everything after the error must vanish
      repeat (30)
         send_byte(8'($urandom_range(255)));
      req_tvalid <= 1'b0;

      waited = 0;
      while (pending_count != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);

      $display("Sent %0d bytes in %0d frames over five register settings, %0d beats checked.",
               bytes_sent, frames_sent, beat_count);
      $display("Stream closed with error case %s and dropped trailing bytes.", bad.name());
      if (fail_count == 0 && pending_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/lpfp_pkg.sv
hw/rtl/lpfp_csr.sv
hw/rtl/lpfp_core.sv
hw/rtl/lpfp_skid.sv
hw/rtl/length_prefixed_frame_parser.sv
hw/rtl/lpfp_checker.sv
verif/length_prefixed_frame_parser_checker.sv
verif/length_prefixed_frame_parser_tb.sv
